// File: rtl/prescaled_interval_timer_core_defines.svh
// ----------------------------------------------------------------------------
// Prescaled interval timer: assertion macros
// Shared assertion forms for the timer RTL; they sample on clk and are
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_INTERVAL_TIMER_CORE_DEFINES_SVH
`define PRESCALED_INTERVAL_TIMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// Prescaled interval timer package
// Field widths, request codes, bus addresses and prescale intervals.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

	localparam int REQ_TYPE_W   = 2;
	localparam int ADDRESS_W    = 16;
	localparam int DATA_W       = 8;
	localparam int PRESCALE_W   = 11;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_type_t;

	localparam logic [ADDRESS_W-1:0] ADDR_OR_MASK = 16'h0280;
	localparam logic [ADDRESS_W-1:0] ADDR_SWCHB   = 16'h0282;
	localparam logic [ADDRESS_W-1:0] ADDR_INTIM   = 16'h0284;
	localparam logic [ADDRESS_W-1:0] ADDR_TIM1T   = 16'h0294;
	localparam logic [ADDRESS_W-1:0] ADDR_TIM8T   = 16'h0295;
	localparam logic [ADDRESS_W-1:0] ADDR_TIM64T  = 16'h0296;
	localparam logic [ADDRESS_W-1:0] ADDR_T1024T  = 16'h0297;

	localparam logic [DATA_W-1:0] SWCHB_VALUE = 8'h0B;
	localparam logic [DATA_W-1:0] COUNT_WRAP  = 8'hFF;
	localparam logic [DATA_W-1:0] COUNT_RESET = 8'h01;

	localparam logic [PRESCALE_W-1:0] PRESCALE_DIV1    = 11'd1;
	localparam logic [PRESCALE_W-1:0] PRESCALE_DIV8    = 11'd8;
	localparam logic [PRESCALE_W-1:0] PRESCALE_DIV64   = 11'd64;
	localparam logic [PRESCALE_W-1:0] PRESCALE_DIV1024 = 11'd1024;

endpackage

`default_nettype wire

// File: rtl/pit_if.sv
// ----------------------------------------------------------------------------
// Prescaled interval timer channels
// Request channel (tick, read, write) and response channel (read byte).
// ----------------------------------------------------------------------------
`default_nettype none

interface pit_req_if import pit_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [ADDRESS_W-1:0]  address;
	logic [DATA_W-1:0]     write_data;

	modport source (output valid, output req_type, output address, output write_data,
		input ready);
	modport sink (input valid, input req_type, input address, input write_data,
		output ready);
endinterface

interface pit_rsp_if import pit_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/prescaled_interval_timer_core.sv
// A word accepted on req passes the input register, then the response register.
// Throughput: one word per cycle while rsp is ready; these two registers form a
// two-entry pipeline, so req takes one more word while a response waits.
// The timer state is updated as a word leaves the input register.
// Reset: arst_n clears both stages and sets count, interval and prescaler to one.
// ----------------------------------------------------------------------------
// Prescaled interval timer core
// RIOT-style interval timer with a 1/8/64/1024 prescaler and an 8-bit count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "prescaled_interval_timer_core_defines.svh"

module prescaled_interval_timer_core import pit_pkg::*; (
	input wire         clk,
	input wire         arst_n,
	pit_req_if.sink    req,
	pit_rsp_if.source  rsp
);

	// Input register
	logic                  valid_s1;
	req_type_t             req_type_s1;
	logic [ADDRESS_W-1:0]  address_s1;
	logic [DATA_W-1:0]     write_data_s1;

	// Timer state
	logic [DATA_W-1:0]     count_q;
	logic [PRESCALE_W-1:0] interval_q;
	logic [PRESCALE_W-1:0] remaining_q;

	// Response register
	logic                  out_valid_q;
	logic [DATA_W-1:0]     read_data_q;

	logic                  advance;
	logic [ADDRESS_W-1:0]  addr_dec;
	logic [PRESCALE_W-1:0] remaining_dec;
	logic [DATA_W-1:0]     count_dec;
	logic [DATA_W-1:0]     count_n;
	logic [PRESCALE_W-1:0] interval_n;
	logic [PRESCALE_W-1:0] remaining_n;
	logic [DATA_W-1:0]     read_data_n;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req_type_t'(req.req_type);
			address_s1    <= req.address;
			write_data_s1 <= req.write_data;
		end
	end

	assign addr_dec      = address_s1 | ADDR_OR_MASK;
	assign remaining_dec = remaining_q - PRESCALE_W'(1);
	assign count_dec     = count_q - DATA_W'(1);

	always_comb begin
		count_n     = count_q;
		interval_n  = interval_q;
		remaining_n = remaining_q;
		read_data_n = '0;
		unique case (req_type_s1)
			REQ_TICK: begin
				if (remaining_dec == '0) begin
					count_n = count_dec;
					// Once the count wraps, the timer runs at one tick per count.
					if (count_dec == COUNT_WRAP) begin
						interval_n  = PRESCALE_DIV1;
						remaining_n = PRESCALE_DIV1;
					end else begin
						remaining_n = interval_q;
					end
				end else begin
					remaining_n = remaining_dec;
				end
			end
			REQ_READ: begin
				if (addr_dec == ADDR_SWCHB) begin
					read_data_n = SWCHB_VALUE;
				end else if (addr_dec == ADDR_INTIM) begin
					read_data_n = count_q;
				end
			end
			REQ_WRITE: begin
				unique case (addr_dec)
					ADDR_TIM1T: begin
						count_n     = write_data_s1;
						interval_n  = PRESCALE_DIV1;
						remaining_n = PRESCALE_DIV1;
					end
					ADDR_TIM8T: begin
						count_n     = write_data_s1;
						interval_n  = PRESCALE_DIV8;
						remaining_n = PRESCALE_DIV8;
					end
					ADDR_TIM64T: begin
						count_n     = write_data_s1;
						interval_n  = PRESCALE_DIV64;
						remaining_n = PRESCALE_DIV64;
					end
					ADDR_T1024T: begin
						count_n     = write_data_s1;
						interval_n  = PRESCALE_DIV1024;
						remaining_n = PRESCALE_DIV1024;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_RESET;
			interval_q  <= PRESCALE_DIV1;
			remaining_q <= PRESCALE_DIV1;
		end else if (valid_s1 && advance) begin
			count_q     <= count_n;
			interval_q  <= interval_n;
			remaining_q <= remaining_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			read_data_q <= read_data_n;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;

	`PIT_ASSERT_NOW(a_remaining_nonzero, 1'b1, remaining_q != '0, "prescaler holds zero")
	`PIT_ASSERT_NOW(a_interval_onehot, 1'b1, $onehot(interval_q), "bad prescale interval")
	`PIT_ASSERT_NOW(a_remaining_le_interval, 1'b1, remaining_q <= interval_q,
		"prescaler above interval")
	`PIT_ASSERT_NEXT(a_stall_holds_state, valid_s1 && !advance,
		$stable(count_q) && $stable(remaining_q), "timer state moved during stall")

endmodule

`default_nettype wire
